// ----- rtl/core/kpib_pkg.sv -----
// ----------------------------------------------------------------------------
// kpib_pkg
// Shared types and constants for the k-mer position index builder.
// ----------------------------------------------------------------------------
`default_nettype none
package kpib_pkg;

  // Transaction kinds
  localparam logic [1:0] KIND_COUNT    = 2'd0;
  localparam logic [1:0] KIND_FINALIZE = 2'd1;
  localparam logic [1:0] KIND_FILL     = 2'd2;
  localparam logic [1:0] KIND_LOOKUP   = 2'd3;

  // Configuration register indexes
  localparam logic [0:0] REG_KMER_LENGTH = 1'd0;
  localparam logic [0:0] REG_CUTOFF      = 1'd1;

  localparam logic [3:0] KMER_LENGTH_RESET = 4'd8;
  localparam logic [7:0] CUTOFF_RESET      = 8'd128;
  localparam logic [7:0] COUNT_MAX         = 8'd255;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SWEEP,
    ST_SWEEP_DONE,
    ST_RESULT
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/core/kmer_position_index_builder_core.sv -----
// ----------------------------------------------------------------------------
// kmer_position_index_builder_core
// Two-pass k-mer counting-sort index: count, finalize, fill and lookup.
// ----------------------------------------------------------------------------
// A count transaction reads the table word, then modifies and writes it back;
// fill and lookup then pass through a result state, which waits while the
// output register still holds an unaccepted result. Finalize walks the whole
// k-mer table through its read port, one entry a cycle. After reset the table
// is swept clear before the first item is accepted; configuration writes are
// taken at any time.
`default_nettype none
module kmer_position_index_builder_core #(
  parameter int MAX_KMER_LENGTH   = 8,
  parameter int SLOT_ADDRESS_BITS = 24
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire [1:0]  kind,
  input  wire [1:0]  base,
  input  wire        read_first,
  input  wire [31:0] base_position,
  input  wire [15:0] query_kmer,
  output logic       out_valid,
  input  wire        out_ready,
  output logic       write_valid,
  output logic [23:0] slot_address,
  output logic [31:0] kmer_position,
  output logic [23:0] entry_start,
  output logic [7:0] entry_count,
  output logic       entry_present,
  output logic [24:0] total_positions,
  output logic       slot_overflow,
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire [0:0]  cfg_index,
  input  wire [7:0]  cfg_data
);

  localparam int KB    = 2 * MAX_KMER_LENGTH;
  localparam int DEPTH = 1 << KB;
  localparam int LB    = $clog2(MAX_KMER_LENGTH + 1);
  localparam int SB    = SLOT_ADDRESS_BITS;
  localparam int TB    = SB + 1;

  // Table word: flag, start, count
  localparam int WB = 1 + SB + 8;
  logic [WB-1:0] table_mem [DEPTH];
  logic [WB-1:0] rd_word;
  logic [KB-1:0] rd_addr, wr_addr;
  logic [WB-1:0] wr_word;
  logic          wr_en;

  kpib_pkg::state_t state, state_next;

  logic [3:0]    kmer_length;
  logic [7:0]    occurrence_cutoff;
  logic [KB-1:0] rolling_kmer;
  logic [LB-1:0] bases_in_read;
  logic [TB:0]   running_sum;      // one extra bit catches overflow
  logic          sum_over;
  logic [KB-1:0] sweep_idx;
  logic [KB-1:0] cur_kmer;
  logic          cur_complete;
  logic [1:0]    cur_kind;
  logic [31:0]   cur_pos;

  // Effective k-mer length
  logic [LB-1:0] k_eff;
  always_comb begin
    if (kmer_length == 4'd0) k_eff = LB'(1);
    else if (32'(kmer_length) > MAX_KMER_LENGTH) k_eff = LB'(MAX_KMER_LENGTH);
    else k_eff = LB'(kmer_length);
  end

  logic [KB-1:0] kmask, shift_mask;
  always_comb begin
    kmask      = '0;
    shift_mask = '0;
    for (int i = 0; i < MAX_KMER_LENGTH; i++) begin
      if (i < 32'(k_eff)) kmask[2*i +: 2] = 2'b11;
      if (i + 1 < 32'(k_eff)) shift_mask[2*i +: 2] = 2'b11;
    end
  end

  // Advance the rolling k-mer for a base transaction
  logic [KB-1:0] roll_src, new_kmer;
  logic [LB-1:0] bir_src;
  logic          complete;
  always_comb begin
    roll_src = read_first ? '0 : rolling_kmer;
    bir_src  = read_first ? '0 : bases_in_read;
    new_kmer = ({roll_src[KB-3:0], base}) & kmask;
    complete = (bir_src >= k_eff - LB'(1));
  end

  wire in_fire  = in_valid && in_ready;
  wire out_fire = out_valid && out_ready;
  assign in_ready  = (state == kpib_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      kpib_pkg::ST_CLEAR:
        if (sweep_idx == KB'(DEPTH - 1)) state_next = kpib_pkg::ST_IDLE;
      kpib_pkg::ST_IDLE:
        if (in_fire) begin
          if (kind == kpib_pkg::KIND_FINALIZE) state_next = kpib_pkg::ST_SWEEP;
          else state_next = kpib_pkg::ST_READ;
        end
      kpib_pkg::ST_READ:
        if (cur_kind == kpib_pkg::KIND_COUNT) state_next = kpib_pkg::ST_IDLE;
        else state_next = kpib_pkg::ST_RESULT;
      kpib_pkg::ST_SWEEP:
        if (sweep_idx == KB'(DEPTH - 1)) state_next = kpib_pkg::ST_SWEEP_DONE;
      kpib_pkg::ST_SWEEP_DONE:
        state_next = kpib_pkg::ST_RESULT;
      kpib_pkg::ST_RESULT:
        if (!out_valid || out_ready) state_next = kpib_pkg::ST_IDLE;
      default: state_next = kpib_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= kpib_pkg::ST_CLEAR;
    else state <= state_next;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_length       <= kpib_pkg::KMER_LENGTH_RESET;
      occurrence_cutoff <= kpib_pkg::CUTOFF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == kpib_pkg::REG_KMER_LENGTH) kmer_length <= cfg_data[3:0];
      else occurrence_cutoff <= cfg_data;
    end
  end

  // Sweep pointer: advances during clear and finalize
  logic [KB-1:0] sweep_prev;
  always_ff @(posedge clk) begin
    if (rst) sweep_idx <= '0;
    else if (state == kpib_pkg::ST_CLEAR || state == kpib_pkg::ST_SWEEP)
      sweep_idx <= sweep_idx + KB'(1);
    else sweep_idx <= '0;
    sweep_prev <= sweep_idx;
  end

  // Capture the transaction and advance the rolling k-mer
  always_ff @(posedge clk) begin
    if (rst) begin
      rolling_kmer  <= '0;
      bases_in_read <= '0;
    end else if (in_fire && (kind == kpib_pkg::KIND_COUNT || kind == kpib_pkg::KIND_FILL))
      begin
      rolling_kmer <= new_kmer & shift_mask;
      if (!complete) bases_in_read <= bir_src + LB'(1);
      else bases_in_read <= bir_src;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_kind     <= kind;
      cur_pos      <= base_position - 32'(k_eff - LB'(1));
      cur_complete <= (kind == kpib_pkg::KIND_LOOKUP) ? 1'b1 : complete;
      cur_kmer     <= (kind == kpib_pkg::KIND_LOOKUP) ? (KB'(query_kmer) & kmask)
                                                       : new_kmer;
    end
  end

  // Memory read address
  always_comb begin
    if (state == kpib_pkg::ST_IDLE) begin
      if (kind == kpib_pkg::KIND_LOOKUP) rd_addr = KB'(query_kmer) & kmask;
      else rd_addr = new_kmer;
    end else rd_addr = sweep_idx;
  end

  // Fields of the word read back
  wire          rd_flag  = rd_word[WB-1];
  wire [SB-1:0] rd_start = rd_word[WB-2:8];
  wire [7:0]    rd_cnt   = rd_word[7:0];

  // Count limit: cutoff + 1 saturating at 255
  wire [7:0] limit = (occurrence_cutoff == 8'hFF) ? 8'hFF : occurrence_cutoff + 8'd1;

  // Fill slot
  wire [SB:0] fill_slot = {1'b0, rd_start} + (SB+1)'(rd_cnt);
  wire fill_ok = cur_complete && rd_flag && !fill_slot[SB] && (rd_cnt != kpib_pkg::COUNT_MAX);

  // Finalize step
  wire          fin_keep = (rd_cnt != 8'd0) && (rd_cnt <= occurrence_cutoff);
  wire          fin_room = !running_sum[TB] && !running_sum[SB];
  wire [TB:0]   sum_add  = running_sum + (TB+1)'(rd_cnt);

  // Write-back logic
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_kmer;
    wr_word = rd_word;
    case (state)
      kpib_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = sweep_idx;
        wr_word = '0;
      end
      kpib_pkg::ST_READ: begin
        if (cur_kind == kpib_pkg::KIND_COUNT) begin
          wr_en = cur_complete && (rd_cnt < limit);
          wr_word = {rd_flag, rd_start, rd_cnt + 8'd1};
        end else if (cur_kind == kpib_pkg::KIND_FILL) begin
          wr_en = fill_ok;
          wr_word = {rd_flag, rd_start, rd_cnt + 8'd1};
        end
      end
      kpib_pkg::ST_SWEEP, kpib_pkg::ST_SWEEP_DONE: begin
        if (!(state == kpib_pkg::ST_SWEEP && sweep_idx == '0)) begin
          wr_en   = 1'b1;
          wr_addr = sweep_prev;
          if (fin_keep && fin_room) wr_word = {1'b1, running_sum[SB-1:0], 8'd0};
          else wr_word = {1'b0, rd_start, 8'd0};
        end
      end
      default: ;
    endcase
  end

  // Table memory, one read and one write port
  always_ff @(posedge clk) begin
    if (wr_en) table_mem[wr_addr] <= wr_word;
    rd_word <= table_mem[rd_addr];
  end

  // Prefix sum, saturating at the capacity with a sticky overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      sum_over    <= 1'b0;
    end else if (state == kpib_pkg::ST_IDLE && in_fire && kind == kpib_pkg::KIND_FINALIZE)
      begin
      running_sum <= '0;
      sum_over    <= 1'b0;
    end else if ((state == kpib_pkg::ST_SWEEP && sweep_idx != '0) ||
                 state == kpib_pkg::ST_SWEEP_DONE) begin
      if (fin_keep) begin
        if (sum_add[TB] || (sum_add[SB] && sum_add[SB-1:0] != '0)) begin
          running_sum <= (TB+1)'(1) << SB;
          sum_over    <= 1'b1;
        end else running_sum <= sum_add;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (state == kpib_pkg::ST_RESULT && (!out_valid || out_ready)) out_valid <= 1'b1;
    else if (out_fire) out_valid <= 1'b0;
  end

  // Result payload, captured when the result is formed
  logic          r_wv, r_pres;
  logic [23:0]   r_slot, r_start;
  logic [31:0]   r_pos;
  logic [7:0]    r_cnt;
  always_ff @(posedge clk) begin
    if (state == kpib_pkg::ST_READ) begin
      r_wv    <= (cur_kind == kpib_pkg::KIND_FILL) && fill_ok;
      r_slot  <= ((cur_kind == kpib_pkg::KIND_FILL) && fill_ok) ? 24'(fill_slot) : '0;
      r_pos   <= ((cur_kind == kpib_pkg::KIND_FILL) && fill_ok) ? cur_pos : '0;
      r_pres  <= (cur_kind == kpib_pkg::KIND_LOOKUP) && rd_flag;
      r_start <= ((cur_kind == kpib_pkg::KIND_LOOKUP) && rd_flag) ? 24'(rd_start) : '0;
      r_cnt   <= ((cur_kind == kpib_pkg::KIND_LOOKUP) && rd_flag) ? rd_cnt : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == kpib_pkg::ST_RESULT && (!out_valid || out_ready)) begin
      if (cur_kind == kpib_pkg::KIND_FINALIZE) begin
        write_valid     <= 1'b0;
        slot_address    <= '0;
        kmer_position   <= '0;
        entry_start     <= '0;
        entry_count     <= '0;
        entry_present   <= 1'b0;
        total_positions <= 25'(running_sum);
        slot_overflow   <= sum_over;
      end else begin
        write_valid     <= r_wv;
        slot_address    <= r_slot;
        kmer_position   <= r_pos;
        entry_start     <= r_start;
        entry_count     <= r_cnt;
        entry_present   <= r_pres;
        total_positions <= '0;
        slot_overflow   <= 1'b0;
      end
    end
  end

  // Checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> state == kpib_pkg::ST_IDLE) else $error("accept while busy");
  a_count_no_result: assert property (@(posedge clk) disable iff (rst)
    (state == kpib_pkg::ST_READ && cur_kind == kpib_pkg::KIND_COUNT) |=>
      state == kpib_pkg::ST_IDLE) else $error("count left a result");
  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    running_sum <= ((TB+1)'(1) << SB)) else $error("sum past capacity");
  a_fill_valid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && write_valid) |-> !entry_present) else $error("mixed result");

endmodule
`default_nettype wire
